// ----- design/traffic_light_controller_defines.svh -----
// Assertion helpers for the traffic light controller.
// Both expect clk and arst_n in scope.
`ifndef TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH
`define TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define TLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tlc_pkg.sv -----
package tlc_pkg;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_MAIN_GREEN  = 3'd0;
	localparam logic [2:0] REG_BLINK_GREEN = 3'd1;
	localparam logic [2:0] REG_YELLOW      = 3'd2;
	localparam logic [2:0] REG_LONG_PRESS  = 3'd3;
	localparam logic [2:0] REG_RELEASE     = 3'd4;

	localparam logic [15:0] MAIN_GREEN_RST  = 16'd15000;
	localparam logic [15:0] BLINK_GREEN_RST = 16'd4000;
	localparam logic [15:0] YELLOW_RST      = 16'd3000;
	localparam logic [15:0] LONG_PRESS_RST  = 16'd4000;
	localparam logic [15:0] RELEASE_RST     = 16'd4000;

	localparam logic [11:0] PAT_GREEN_A = 12'h50A;
	localparam logic [11:0] PAT_BLINK_A = 12'h500;
	localparam logic [11:0] PAT_YEL_A   = 12'h5A0;
	localparam logic [11:0] PAT_GREEN_B = 12'hA05;
	localparam logic [11:0] PAT_BLINK_B = 12'hA00;
	localparam logic [11:0] PAT_YEL_B   = 12'hA50;

	localparam logic [9:0] BLINK_HALF = 10'd400;
	localparam logic [9:0] SCAN_LAST  = 10'd1000;
	localparam logic [1:0] ROW_NONE   = 2'd3;

	typedef enum logic [2:0] {
		LP_OFF      = 3'd0,
		LP_GREEN_A  = 3'd1,
		LP_BLINK_A  = 3'd2,
		LP_YELLOW_A = 3'd3,
		LP_GREEN_B  = 3'd4,
		LP_BLINK_B  = 3'd5,
		LP_YELLOW_B = 3'd6
	} light_phase_t;

	typedef enum logic [2:0] {
		PW_IDLE     = 3'd0,
		PW_PRESSED  = 3'd1,
		PW_LONG     = 3'd2,
		PW_RELEASED = 3'd4,
		PW_DOWN     = 3'd5,
		PW_UP       = 3'd6
	} power_phase_t;

	typedef struct packed {
		logic [15:0] main_green_ticks;
		logic [15:0] blink_green_ticks;
		logic [15:0] yellow_ticks;
		logic [15:0] long_press_ticks;
		logic [15:0] release_ticks;
	} tlc_cfg_t;

	typedef struct packed {
		light_phase_t light_phase;
		logic [15:0]  phase_timer;
		power_phase_t power_phase;
		logic [15:0]  press_counter;
		logic [11:0]  lamps;
		logic         power_lamp;
		logic [9:0]   scan_count;
	} tlc_state_t;

	typedef struct packed {
		logic [11:0] lamp_pattern;
		logic        power_led;
		logic [1:0]  scan_row;
		logic [4:0]  scan_columns;
		logic        powered_down;
	} tlc_result_t;

endpackage

// ----- design/tlc_ifs.sv -----
interface tlc_in_if;
	logic valid;
	logic ready;
	logic button_pressed;

	modport source (output valid, output button_pressed, input ready);
	modport sink (input valid, input button_pressed, output ready);
endinterface

interface tlc_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] lamp_pattern;
	logic        power_led;
	logic [1:0]  scan_row;
	logic [4:0]  scan_columns;
	logic        powered_down;

	modport source (output valid, output lamp_pattern, output power_led, output scan_row,
		output scan_columns, output powered_down, input ready);
	modport sink (input valid, input lamp_pattern, input power_led, input scan_row,
		input scan_columns, input powered_down, output ready);
endinterface

// ----- design/tlc_step.sv -----
// One tick of the controller: next state and result from current state.
module tlc_step
	import tlc_pkg::*;
(
	input  tlc_state_t  state_cur,
	input  tlc_cfg_t    cfg,
	input  logic        pressed,
	output tlc_state_t  state_nxt,
	output tlc_result_t res
);

	// t mod 800 via t = 32*a + b, a mod 25 by reciprocal (1311/2^15)
	function automatic logic [9:0] mod800(input logic [15:0] t);
		logic [10:0] a;
		logic [21:0] prod;
		logic [6:0]  q;
		logic [11:0] q25;
		logic [10:0] ra;
		a    = t[15:5];
		prod = {11'd0, a} * 22'd1311;
		q    = prod[21:15];
		q25  = {1'b0, q, 4'd0} + {2'b0, q, 3'd0} + {5'd0, q};
		ra   = a - q25[10:0];
		return {ra[4:0], t[4:0]};
	endfunction

	logic [15:0]  t_dec;
	logic         t_zero;
	logic         blink_on;
	light_phase_t lp_n;
	logic [15:0]  timer_n;
	logic [11:0]  lamps_l;
	power_phase_t pp_n;
	logic [15:0]  cnt_n;
	logic [11:0]  lamps_p;
	logic         plamp_n;
	logic [10:0]  scan_inc;
	logic [1:0]   row;
	logic [3:0]   nib;

	assign t_dec    = state_cur.phase_timer - 16'd1;
	assign t_zero   = (t_dec == 16'd0);
	assign blink_on = (mod800(t_dec) > BLINK_HALF);

	// light cycle
	always_comb begin
		lp_n    = state_cur.light_phase;
		timer_n = t_dec;
		lamps_l = state_cur.lamps;
		unique case (state_cur.light_phase)
			LP_GREEN_A: begin
				if (t_zero) begin
					lp_n    = LP_BLINK_A;
					timer_n = cfg.blink_green_ticks;
				end
			end
			LP_BLINK_A: begin
				if (!t_zero) begin
					lamps_l = blink_on ? PAT_GREEN_A : PAT_BLINK_A;
				end else begin
					lp_n    = LP_YELLOW_A;
					timer_n = cfg.yellow_ticks;
					lamps_l = PAT_YEL_A;
				end
			end
			LP_YELLOW_A: begin
				if (t_zero) begin
					lp_n    = LP_GREEN_B;
					timer_n = cfg.main_green_ticks;
					lamps_l = PAT_GREEN_B;
				end
			end
			LP_GREEN_B: begin
				if (t_zero) begin
					lp_n    = LP_BLINK_B;
					timer_n = cfg.blink_green_ticks;
				end
			end
			LP_BLINK_B: begin
				if (!t_zero) begin
					lamps_l = blink_on ? PAT_GREEN_B : PAT_BLINK_B;
				end else begin
					lp_n    = LP_YELLOW_B;
					timer_n = cfg.yellow_ticks;
					lamps_l = PAT_YEL_B;
				end
			end
			LP_YELLOW_B: begin
				if (t_zero) begin
					lp_n = LP_OFF;
				end
			end
			default: begin
				lp_n    = LP_GREEN_A;
				timer_n = cfg.main_green_ticks;
				lamps_l = PAT_GREEN_A;
			end
		endcase
	end

	// power button, runs after the light cycle
	always_comb begin
		pp_n    = state_cur.power_phase;
		cnt_n   = state_cur.press_counter;
		lamps_p = lamps_l;
		plamp_n = state_cur.power_lamp;
		unique case (state_cur.power_phase)
			PW_IDLE: begin
				if (pressed) begin
					cnt_n = cfg.long_press_ticks;
					pp_n  = PW_PRESSED;
				end else begin
					plamp_n = 1'b0;
				end
			end
			PW_PRESSED: begin
				if (pressed) begin
					cnt_n = state_cur.press_counter - 16'd1;
					if (state_cur.press_counter == 16'd0) begin
						plamp_n = 1'b1;
						pp_n    = PW_LONG;
					end
				end else begin
					pp_n = PW_IDLE;
				end
			end
			PW_LONG: begin
				if (!pressed) begin
					cnt_n = cfg.release_ticks;
					pp_n  = PW_RELEASED;
				end
			end
			PW_RELEASED: begin
				if (!pressed) begin
					cnt_n = state_cur.press_counter - 16'd1;
					if (state_cur.press_counter == 16'd0) begin
						plamp_n = 1'b0;
						lamps_p = 12'd0;
						pp_n    = PW_DOWN;
					end
				end else begin
					pp_n = PW_IDLE;
				end
			end
			PW_UP: begin
				if (!pressed) begin
					plamp_n = 1'b0;
					pp_n    = PW_IDLE;
				end
			end
			default: ;
		endcase
	end

	assign scan_inc = {1'b0, state_cur.scan_count} + 11'd1;
	assign row      = state_cur.scan_count[1:0];

	always_comb begin
		unique case (row)
			2'd0:    nib = lamps_p[3:0];
			2'd1:    nib = lamps_p[7:4];
			2'd2:    nib = lamps_p[11:8];
			default: nib = 4'd0;
		endcase
	end

	// state and result
	always_comb begin
		state_nxt = state_cur;
		res       = '0;
		if (state_cur.power_phase == PW_DOWN) begin
			if (pressed) begin
				state_nxt.power_lamp  = 1'b1;
				state_nxt.power_phase = PW_UP;
				state_nxt.light_phase = LP_OFF;
			end
			res.scan_row     = ROW_NONE;
			res.scan_columns = 5'd0;
		end else begin
			state_nxt.light_phase   = lp_n;
			state_nxt.phase_timer   = timer_n;
			state_nxt.power_phase   = pp_n;
			state_nxt.press_counter = cnt_n;
			state_nxt.lamps         = lamps_p;
			state_nxt.power_lamp    = plamp_n;
			state_nxt.scan_count    = (scan_inc[9:0] > SCAN_LAST) ? 10'd0 : scan_inc[9:0];
			res.scan_row            = row;
			res.scan_columns        = (row == ROW_NONE) ? 5'd0 : {plamp_n, nib};
		end
		res.lamp_pattern = state_nxt.lamps;
		res.power_led    = state_nxt.power_lamp;
		res.powered_down = (state_nxt.power_phase == PW_DOWN);
	end

endmodule

// ----- design/traffic_light_controller.sv -----
// Channel  Dir  Contents of one word
// -------  ---  ---------------------------------------------------------------
// tick     in   button_pressed: power button level for this tick
// result   out  lamp_pattern, power_led, scan_row, scan_columns, powered_down
// apb      in   five 16-bit timing registers at byte addresses 0,4,8,12,16
//
// One word per cycle sustained while the result is not stalled.
// Tick words are latched into stage 1; the whole step (timer, light cycle, button FSM,
// scan) is one combinational pass into the stage-2 result register.
// A stalled result holds stage 2; stage 1 keeps taking a word while it is empty.
// arst_n clears all control state and loads the register defaults.
`include "traffic_light_controller_defines.svh"

module traffic_light_controller
	import tlc_pkg::*;
#(
	parameter logic [15:0] MAIN_GREEN_DEF  = MAIN_GREEN_RST,
	parameter logic [15:0] BLINK_GREEN_DEF = BLINK_GREEN_RST,
	parameter logic [15:0] YELLOW_DEF      = YELLOW_RST,
	parameter logic [15:0] LONG_PRESS_DEF  = LONG_PRESS_RST,
	parameter logic [15:0] RELEASE_DEF     = RELEASE_RST
) (
	input  logic              clk,
	input  logic              arst_n,
	tlc_in_if.sink            tick,
	tlc_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	tlc_cfg_t    cfg_q;
	tlc_state_t  state_q;
	tlc_state_t  state_d;
	tlc_result_t res_d;
	tlc_result_t res_s2;
	logic        v_s1;
	logic        button_s1;
	logic        v_s2;
	logic        load_s2;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	// ---------------- config port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_green_ticks  <= MAIN_GREEN_DEF;
			cfg_q.blink_green_ticks <= BLINK_GREEN_DEF;
			cfg_q.yellow_ticks      <= YELLOW_DEF;
			cfg_q.long_press_ticks  <= LONG_PRESS_DEF;
			cfg_q.release_ticks     <= RELEASE_DEF;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAIN_GREEN:  cfg_q.main_green_ticks  <= pwdata[15:0];
				REG_BLINK_GREEN: cfg_q.blink_green_ticks <= pwdata[15:0];
				REG_YELLOW:      cfg_q.yellow_ticks      <= pwdata[15:0];
				REG_LONG_PRESS:  cfg_q.long_press_ticks  <= pwdata[15:0];
				REG_RELEASE:     cfg_q.release_ticks     <= pwdata[15:0];
				default: ;  // unmapped, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAIN_GREEN:  prdata = {16'd0, cfg_q.main_green_ticks};
			REG_BLINK_GREEN: prdata = {16'd0, cfg_q.blink_green_ticks};
			REG_YELLOW:      prdata = {16'd0, cfg_q.yellow_ticks};
			REG_LONG_PRESS:  prdata = {16'd0, cfg_q.long_press_ticks};
			REG_RELEASE:     prdata = {16'd0, cfg_q.release_ticks};
			default:         prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// stage 2 loads a valid stage-1 word when it is empty or its word leaves this cycle
	assign load_s2    = v_s1 && (!v_s2 || result.ready);
	assign tick.ready = !v_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (tick.ready) begin
				v_s1 <= tick.valid;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// stage 1: latch the button word
	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			button_s1 <= tick.button_pressed;
		end
	end

	// ---------------- one tick of work ----------------
	tlc_step u_step (
		.state_cur (state_q),
		.cfg       (cfg_q),
		.pressed   (button_s1),
		.state_nxt (state_d),
		.res       (res_d)
	);

	// state commits together with the result it produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.light_phase   <= LP_OFF;
			state_q.phase_timer   <= 16'd0;
			state_q.power_phase   <= PW_IDLE;
			state_q.press_counter <= 16'd0;
			state_q.lamps         <= 12'd0;
			state_q.power_lamp    <= 1'b0;
			state_q.scan_count    <= 10'd0;
		end else if (load_s2) begin
			state_q <= state_d;
		end
	end

	// stage 2: result register
	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid        = v_s2;
	assign result.lamp_pattern = res_s2.lamp_pattern;
	assign result.power_led    = res_s2.power_led;
	assign result.scan_row     = res_s2.scan_row;
	assign result.scan_columns = res_s2.scan_columns;
	assign result.powered_down = res_s2.powered_down;

	// ---------------- assertions ----------------
	`TLC_ASSERT_NOW(a_scan_range, 1'b1, state_q.scan_count <= SCAN_LAST, "scan count out of range")
	`TLC_ASSERT_NOW(a_row_none_dark, v_s2 && (res_s2.scan_row == ROW_NONE), res_s2.scan_columns == 5'd0, "row three shows columns")
	`TLC_ASSERT_NOW(a_down_dark, v_s2 && res_s2.powered_down, (res_s2.lamp_pattern == 12'd0) && !res_s2.power_led && (res_s2.scan_columns == 5'd0), "lamps lit while powered down")
	`TLC_ASSERT_NEXT(a_stall_keeps, v_s2 && !result.ready, v_s2, "stalled result dropped")

endmodule
